FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked while out of reset
`define WBRC_ASSERT(name, clk_i, rstn_i, prop) \
	name: assert property (@(posedge clk_i) disable iff (!rstn_i) (prop)) \
		else $error("wbrc: check failed");
// checked at every edge, reset included
`define WBRC_ASSERT_ALWAYS(name, clk_i, prop) \
	name: assert property (@(posedge clk_i) (prop)) \
		else $error("wbrc: check failed");
`else
`define WBRC_ASSERT(name, clk_i, rstn_i, prop)
`define WBRC_ASSERT_ALWAYS(name, clk_i, prop)
`endif
`endif

FILE: rtl/core/wbrc_pkg.sv
// ----------------------------------------------------------------------------
// wbrc_pkg
// shared types and constants of the banked window rectangle copy planner
// ----------------------------------------------------------------------------
package wbrc_pkg;

	localparam int CFG_W      = 27;
	localparam int CFG_IDX_W  = 2;
	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 104;
	localparam int OUT_USER_W = 3;
	localparam int NUM_SLOTS  = 3;

	// offset divider
	localparam int DVD_W      = 31;
	localparam int DVS_W      = 27;
	localparam int DIV_CNT_W  = $clog2(DVD_W);

	localparam logic [14:0] MAX_SCREEN = 15'd16384;
	localparam logic [16:0] MAX_STRIDE = 17'd65536;
	localparam logic [26:0] MAX_APER   = 27'd67108864;

	localparam logic [14:0] RST_SCREEN_WIDTH  = 15'd640;
	localparam logic [14:0] RST_SCREEN_HEIGHT = 15'd480;
	localparam logic [16:0] RST_ROW_STRIDE    = 17'd640;
	localparam logic [26:0] RST_APERTURE      = 27'd65536;

	typedef enum logic [1:0] {
		REG_SCREEN_WIDTH  = 2'd0,
		REG_SCREEN_HEIGHT = 2'd1,
		REG_ROW_STRIDE    = 2'd2,
		REG_APERTURE_SIZE = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ACT_SELECT = 2'd0,
		ACT_COPY   = 2'd1,
		ACT_NONE   = 2'd2
	} act_t;

	typedef struct packed {
		act_t        action;
		logic [29:0] bank;
		logic [29:0] source_offset;
		logic [25:0] window_offset;
		logic [14:0] length;
	} res_t;

	typedef struct packed {
		logic       cap;
		logic       plan;
		logic       mul;
		logic       offs;
		logic       fin;
		logic       emit;
		logic [1:0] idx;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic       need_div;
		logic       div_done;
		logic       out_free;
		logic [1:0] n;
	} sts_t;

endpackage

FILE: rtl/core/banked_window_rect_copy_planner_top.sv
// a row word is captured, then planned, then its result words leave the output register,
// one per cycle unless the output stalls; n results (1 to 3); no new word until all are out
// a start word passes the offset multiply and then a bit-serial divide of the byte offset
// by the aperture size (31 iterations); a start word that clips to nothing skips both
// reset: arst_n clears the controller, the planner state and the registers to defaults
// ----------------------------------------------------------------------------
// banked_window_rect_copy_planner_top
// plans banked window copies of a clipped 8 bpp shadow buffer rectangle
// ----------------------------------------------------------------------------
module banked_window_rect_copy_planner_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [wbrc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [wbrc_pkg::CFG_W-1:0]       cfg_data,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// left, top, right, bottom
	input  logic [wbrc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// kind
	input  logic [0:0]                       s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// bank, source_offset, window_offset, length, zero pad
	output logic [wbrc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	// action, rect_done
	output logic [wbrc_pkg::OUT_USER_W-1:0]  m_axis_tuser,
	output logic                             m_axis_tlast
);

	wbrc_pkg::cmd_t cmd;
	wbrc_pkg::sts_t sts;

	wbrc_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.sts           (sts),
		.cmd           (cmd)
	);

	wbrc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cmd           (cmd),
		.sts           (sts)
	);

endmodule

FILE: rtl/core/wbrc_div.sv
// ----------------------------------------------------------------------------
// wbrc_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module wbrc_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [wbrc_pkg::DVD_W-1:0]  dividend,
	input  logic [wbrc_pkg::DVS_W-1:0]  divisor,
	output logic                        done,
	output logic [wbrc_pkg::DVD_W-1:0]  quo,
	output logic [wbrc_pkg::DVS_W-1:0]  rem
);

	localparam int DVD_W = wbrc_pkg::DVD_W;
	localparam int DVS_W = wbrc_pkg::DVS_W;
	localparam int CNT_W = wbrc_pkg::DIV_CNT_W;

	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] rem_next;
	logic [DVS_W:0]   trial;
	logic             fit;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	assign trial    = {rem_q, dvd_q[DVD_W-1]};
	assign fit      = trial >= {1'b0, divisor};
	assign rem_next = fit ? DVS_W'(trial - {1'b0, divisor}) : trial[DVS_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(DVD_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], fit};
			rem_q <= rem_next;
		end
	end

	assign done = done_q;
	assign quo  = dvd_q;
	assign rem  = rem_q;

endmodule

FILE: rtl/core/wbrc_dp.sv
// ----------------------------------------------------------------------------
// wbrc_dp
// datapath: registers, clipping, offset math, row planning, output register
// ----------------------------------------------------------------------------
module wbrc_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [wbrc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [wbrc_pkg::CFG_W-1:0]          cfg_data,
	input  logic [wbrc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	input  logic [0:0]                          s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [wbrc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	output logic [wbrc_pkg::OUT_USER_W-1:0]     m_axis_tuser,
	output logic                                m_axis_tlast,
	input  wbrc_pkg::cmd_t                      cmd,
	output wbrc_pkg::sts_t                      sts
);

	function automatic wbrc_pkg::res_t mk_copy(input logic [29:0] src,
		input logic [25:0] win, input logic [14:0] len);
		wbrc_pkg::res_t r;
		r               = '0;
		r.action        = wbrc_pkg::ACT_COPY;
		r.source_offset = src;
		r.window_offset = win;
		r.length        = len;
		return r;
	endfunction

	function automatic wbrc_pkg::res_t mk_select(input logic [29:0] bank);
		wbrc_pkg::res_t r;
		r        = '0;
		r.action = wbrc_pkg::ACT_SELECT;
		r.bank   = bank;
		return r;
	endfunction

	function automatic wbrc_pkg::res_t mk_none();
		wbrc_pkg::res_t r;
		r        = '0;
		r.action = wbrc_pkg::ACT_NONE;
		return r;
	endfunction

	// configuration
	logic [14:0] sw_q, sh_q;
	logic [16:0] stride_q;
	logic [26:0] aper_q;
	logic [14:0] w_eff, h_eff;
	logic [16:0] s_eff;
	logic [26:0] a_eff;

	// captured word
	logic               kind_q;
	logic signed [15:0] left_q, top_q, right_q, bottom_q;

	// planner state
	logic [29:0] cur_bank_q;
	logic [31:0] wpos_q;
	logic [30:0] spos_q;
	logic [14:0] row_bytes_q;
	logic [14:0] rows_left_q;
	logic [13:0] t_q, l_q;
	logic [30:0] prod_q;
	logic [30:0] off;

	wbrc_pkg::res_t res_q [wbrc_pkg::NUM_SLOTS];
	logic [1:0]     n_q;
	logic           done_q;

	// clipping
	logic [15:0]        l_c, t_c;
	logic signed [16:0] w_s, h_s, r_ext, b_ext, r_c, b_c;
	logic signed [17:0] wdiff, hdiff;
	logic               empty;
	logic               no_rows;

	// row planning
	logic [32:0]    row_sum;
	logic           row_cross;
	logic [26:0]    room;
	logic           room_gt_len;
	logic           has_a, has_c;
	logic [14:0]    len_a;
	logic [29:0]    bank_inc;
	wbrc_pkg::res_t copy_a, copy_c, sel;
	wbrc_pkg::res_t row_res [wbrc_pkg::NUM_SLOTS];
	logic [1:0]     row_n;
	logic [31:0]    row_wpos;
	logic [29:0]    row_bank;
	logic [30:0]    row_spos;

	// divider
	logic                        div_done;
	logic [wbrc_pkg::DVD_W-1:0]  div_quo;
	logic [wbrc_pkg::DVS_W-1:0]  div_rem;

	// output register
	logic           m_valid_q;
	wbrc_pkg::res_t out_res_q;
	logic           out_last_q;
	logic           out_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q     <= wbrc_pkg::RST_SCREEN_WIDTH;
			sh_q     <= wbrc_pkg::RST_SCREEN_HEIGHT;
			stride_q <= wbrc_pkg::RST_ROW_STRIDE;
			aper_q   <= wbrc_pkg::RST_APERTURE;
		end else if (cfg_we) begin
			case (cfg_index)
				wbrc_pkg::REG_SCREEN_WIDTH:  sw_q     <= cfg_data[14:0];
				wbrc_pkg::REG_SCREEN_HEIGHT: sh_q     <= cfg_data[14:0];
				wbrc_pkg::REG_ROW_STRIDE:    stride_q <= cfg_data[16:0];
				wbrc_pkg::REG_APERTURE_SIZE: aper_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign w_eff = (sw_q > wbrc_pkg::MAX_SCREEN) ? wbrc_pkg::MAX_SCREEN : sw_q;
	assign h_eff = (sh_q > wbrc_pkg::MAX_SCREEN) ? wbrc_pkg::MAX_SCREEN : sh_q;
	assign s_eff = (stride_q > wbrc_pkg::MAX_STRIDE) ? wbrc_pkg::MAX_STRIDE : stride_q;
	assign a_eff = (aper_q > wbrc_pkg::MAX_APER) ? wbrc_pkg::MAX_APER :
		(aper_q == '0) ? 27'd1 : aper_q;

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			kind_q   <= s_axis_tuser[0];
			left_q   <= s_axis_tdata[15:0];
			top_q    <= s_axis_tdata[31:16];
			right_q  <= s_axis_tdata[47:32];
			bottom_q <= s_axis_tdata[63:48];
		end
	end

	// clip to the screen
	assign l_c   = left_q[15] ? 16'd0 : left_q;
	assign t_c   = top_q[15] ? 16'd0 : top_q;
	assign w_s   = $signed({2'b00, w_eff});
	assign h_s   = $signed({2'b00, h_eff});
	assign r_ext = $signed({right_q[15], right_q});
	assign b_ext = $signed({bottom_q[15], bottom_q});
	assign r_c   = (r_ext > w_s) ? w_s : r_ext;
	assign b_c   = (b_ext > h_s) ? h_s : b_ext;
	assign wdiff = {r_c[16], r_c} - $signed({2'b00, l_c});
	assign hdiff = {b_c[16], b_c} - $signed({2'b00, t_c});
	assign empty = wdiff[17] || (wdiff == 18'sd0) || hdiff[17] || (hdiff == 18'sd0);
	assign no_rows = rows_left_q == '0;

	// one row of copies
	always_comb begin
		row_sum     = {1'b0, wpos_q} + 33'(s_eff);
		row_cross   = row_sum >= 33'(a_eff);
		room        = (wpos_q < 32'(a_eff)) ? (a_eff - wpos_q[26:0]) : '0;
		room_gt_len = room > 27'(row_bytes_q);
		has_a       = room != '0;
		has_c       = 27'(row_bytes_q) > room;
		len_a       = (!row_cross || room_gt_len) ? row_bytes_q : room[14:0];
		bank_inc    = cur_bank_q + 30'd1;
		copy_a      = mk_copy(spos_q[29:0], wpos_q[25:0], len_a);
		copy_c      = mk_copy(spos_q[29:0] + 30'(room), 26'd0, row_bytes_q - room[14:0]);
		sel         = mk_select(bank_inc);
		row_res[0]  = copy_a;
		row_res[1]  = sel;
		row_res[2]  = copy_c;
		row_n       = 2'd1;
		if (row_cross) begin
			row_res[0] = has_a ? copy_a : sel;
			row_res[1] = has_a ? sel : copy_c;
			row_n      = 2'd1 + 2'(has_a) + 2'(has_c);
		end
		row_wpos = row_cross ? 32'(row_sum - 33'(a_eff)) : row_sum[31:0];
		row_bank = row_cross ? bank_inc : cur_bank_q;
		row_spos = spos_q + 31'(s_eff);
	end

	assign off = prod_q + 31'(l_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_bank_q  <= '0;
			wpos_q      <= '0;
			spos_q      <= '0;
			row_bytes_q <= '0;
			rows_left_q <= '0;
		end else begin
			if (cmd.plan) begin
				if (!kind_q) begin
					if (empty) begin
						rows_left_q <= '0;
					end else begin
						row_bytes_q <= wdiff[14:0];
						rows_left_q <= hdiff[14:0];
					end
				end else if (!no_rows) begin
					wpos_q      <= row_wpos;
					cur_bank_q  <= row_bank;
					spos_q      <= row_spos;
					rows_left_q <= rows_left_q - 15'd1;
				end
			end
			if (cmd.offs) begin
				spos_q <= off;
			end
			if (cmd.fin) begin
				cur_bank_q <= div_quo[29:0];
				wpos_q     <= {6'd0, div_rem[25:0]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.plan && !kind_q) begin
			t_q <= t_c[13:0];
			l_q <= l_c[13:0];
		end
		if (cmd.mul) begin
			prod_q <= 31'(t_q) * 31'(s_eff);
		end
	end

	// result slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q    <= '0;
			done_q <= 1'b0;
		end else if (cmd.plan) begin
			if (!kind_q || no_rows) begin
				n_q    <= 2'd1;
				done_q <= 1'b1;
			end else begin
				n_q    <= row_n;
				done_q <= rows_left_q == 15'd1;
			end
		end else if (cmd.fin) begin
			n_q    <= 2'd1;
			done_q <= no_rows;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.plan) begin
			if (!kind_q || no_rows) begin
				res_q[0] <= mk_none();
			end else begin
				res_q <= row_res;
			end
		end else if (cmd.fin) begin
			res_q[0] <= mk_select(div_quo[29:0]);
		end
	end

	wbrc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.offs),
		.dividend (off),
		.divisor  (a_eff),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_res_q  <= res_q[cmd.idx];
			out_last_q <= cmd.last;
			out_done_q <= done_q;
		end
	end

	assign sts.need_div = !kind_q && !empty;
	assign sts.div_done = div_done;
	assign sts.out_free = !m_valid_q || m_axis_tready;
	assign sts.n        = n_q;

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {3'b000, out_res_q.length, out_res_q.window_offset,
		out_res_q.source_offset, out_res_q.bank};
	assign m_axis_tuser  = {out_done_q, out_res_q.action};
	assign m_axis_tlast  = out_last_q;

endmodule

FILE: rtl/core/wbrc_ctrl.sv
// ----------------------------------------------------------------------------
// wbrc_ctrl
// controller: sequences decode, offset math and result emission
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wbrc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_axis_tvalid,
	output logic            s_axis_tready,
	input  wbrc_pkg::sts_t  sts,
	output wbrc_pkg::cmd_t  cmd
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_DECODE = 6'b000010,
		ST_MUL    = 6'b000100,
		ST_OFFS   = 6'b001000,
		ST_DIV    = 6'b010000,
		ST_EMIT   = 6'b100000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] idx_q, idx_d;
	logic       is_last;

	assign is_last = idx_q == 2'(sts.n - 2'd1);

	always_comb begin
		cmd           = '0;
		cmd.idx       = idx_q;
		cmd.last      = is_last;
		s_axis_tready = 1'b0;
		state_d       = state_q;
		idx_d         = idx_q;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					cmd.cap = 1'b1;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.plan = 1'b1;
				state_d  = sts.need_div ? ST_MUL : ST_EMIT;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_OFFS;
			end
			ST_OFFS: begin
				cmd.offs = 1'b1;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_done) begin
					cmd.fin = 1'b1;
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (is_last) begin
						idx_d   = '0;
						state_d = ST_IDLE;
					end else begin
						idx_d = idx_q + 2'd1;
					end
				end
			end
			default: begin
				idx_d   = '0;
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	`WBRC_ASSERT(a_emit_idx_range, clk, arst_n, (state_q == ST_EMIT) |-> (idx_q < sts.n))
	`WBRC_ASSERT(a_idle_idx_clear, clk, arst_n, (state_q == ST_IDLE) |-> (idx_q == 2'd0))
	`WBRC_ASSERT_ALWAYS(a_div_done_waited, clk, sts.div_done |-> (state_q == ST_DIV))

endmodule

FILE: verif/copy_plan_checker.sv
// ----------------------------------------------------------------------------
// copy_plan_checker
// watches the config port and both streams of the copy planner, predicts the
// select, copy and empty words of every accepted input word, and compares them
// in order with the words the planner hands out
// ----------------------------------------------------------------------------
module copy_plan_checker
	import wbrc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	// left, top, right, bottom
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// kind
	input  logic [0:0]            s_axis_tuser,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// bank, source_offset, window_offset, length, zero pad
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,
	// action, rect_done
	input  logic [OUT_USER_W-1:0] m_axis_tuser,
	input  logic                  m_axis_tlast,
	output int                    mismatches,
	output int                    outstanding
);

	typedef struct {
		act_t        action;
		logic [29:0] bank;
		logic [29:0] source_offset;
		logic [25:0] window_offset;
		logic [14:0] length;
		logic        last_of_run;
		logic        rect_done;
	} plan_cmd_t;

	plan_cmd_t planned_q[$];

	logic [14:0] scr_width;
	logic [14:0] scr_height;
	logic [16:0] stride;
	logic [26:0] aperture;

	logic [29:0] bank_now;
	logic [31:0] win_pos;
	logic [30:0] src_pos;
	logic [14:0] row_len;
	logic [14:0] rows_remaining;

	function automatic plan_cmd_t mk_cmd(act_t act, longint bank, longint src, longint win,
		longint len);
		plan_cmd_t c;
		c.action        = act;
		c.bank          = bank[29:0];
		c.source_offset = src[29:0];
		c.window_offset = win[25:0];
		c.length        = len[14:0];
		c.last_of_run   = 1'b0;
		c.rect_done     = 1'b0;
		return c;
	endfunction

	task automatic plan_word(input logic kind, input logic [63:0] d);
		longint ap, st, w, h, l, t, r, b, off, p, src, len, room;
		int first;
		int k;
		ap = (aperture > MAX_APER) ? MAX_APER : aperture;
		if (ap == 0)
			ap = 1;
		st = (stride > MAX_STRIDE) ? MAX_STRIDE : stride;
		first = planned_q.size();
		if (kind == 1'b0) begin
			w = (scr_width > MAX_SCREEN) ? MAX_SCREEN : scr_width;
			h = (scr_height > MAX_SCREEN) ? MAX_SCREEN : scr_height;
			l = longint'($signed(d[15:0]));
			t = longint'($signed(d[31:16]));
			r = longint'($signed(d[47:32]));
			b = longint'($signed(d[63:48]));
			if (l < 0) l = 0;
			if (t < 0) t = 0;
			if (r > w) r = w;
			if (b > h) b = h;
			if (r - l < 1 || b - t < 1) begin
				rows_remaining = '0;
				planned_q.push_back(mk_cmd(ACT_NONE, 0, 0, 0, 0));
			end else begin
				off = t * st + l;
				row_len = 15'(r - l);
				rows_remaining = 15'(b - t);
				src_pos = 31'(off);
				bank_now = 30'(off / ap);
				win_pos = 32'(off % ap);
				planned_q.push_back(mk_cmd(ACT_SELECT, bank_now, 0, 0, 0));
			end
		end else if (rows_remaining == 0) begin
			planned_q.push_back(mk_cmd(ACT_NONE, 0, 0, 0, 0));
		end else begin
			p = win_pos;
			src = src_pos;
			len = row_len;
			if (p + st < ap) begin
				planned_q.push_back(mk_cmd(ACT_COPY, 0, src, p, len));
				p = p + st;
			end else begin
				// row reaches the end of the window
				room = (p < ap) ? ap - p : 0;
				bank_now = bank_now + 30'd1;
				if (room > len) begin
					planned_q.push_back(mk_cmd(ACT_COPY, 0, src, p, len));
					planned_q.push_back(mk_cmd(ACT_SELECT, bank_now, 0, 0, 0));
				end else begin
					if (room > 0)
						planned_q.push_back(mk_cmd(ACT_COPY, 0, src, p, room));
					planned_q.push_back(mk_cmd(ACT_SELECT, bank_now, 0, 0, 0));
					if (len > room)
						planned_q.push_back(mk_cmd(ACT_COPY, 0, src + room, 0, len - room));
				end
				p = p + st - ap;
			end
			win_pos = 32'(p);
			src_pos = 31'(src + st);
			rows_remaining = rows_remaining - 15'd1;
		end
		for (k = first; k < planned_q.size(); k++)
			planned_q[k].rect_done = (rows_remaining == 0);
		planned_q[planned_q.size() - 1].last_of_run = 1'b1;
	endtask

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endfunction

	task automatic check_word();
		plan_cmd_t e;
		if (planned_q.size() == 0) begin
			$error("word with none predicted: action %0d", m_axis_tuser[1:0]);
			mismatches++;
		end else begin
			e = planned_q.pop_front();
			check_field("action", e.action, m_axis_tuser[1:0]);
			check_field("bank", e.bank, m_axis_tdata[29:0]);
			check_field("source_offset", e.source_offset, m_axis_tdata[59:30]);
			check_field("window_offset", e.window_offset, m_axis_tdata[85:60]);
			check_field("length", e.length, m_axis_tdata[100:86]);
			check_field("last_of_run", e.last_of_run, m_axis_tlast);
			check_field("rect_done", e.rect_done, m_axis_tuser[2]);
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			scr_width = RST_SCREEN_WIDTH;
			scr_height = RST_SCREEN_HEIGHT;
			stride = RST_ROW_STRIDE;
			aperture = RST_APERTURE;
			bank_now = '0;
			win_pos = '0;
			src_pos = '0;
			row_len = '0;
			rows_remaining = '0;
			planned_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SCREEN_WIDTH:  scr_width = cfg_data[14:0];
					REG_SCREEN_HEIGHT: scr_height = cfg_data[14:0];
					REG_ROW_STRIDE:    stride = cfg_data[16:0];
					REG_APERTURE_SIZE: aperture = cfg_data[26:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				plan_word(s_axis_tuser[0], s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				check_word();
		end
		outstanding = planned_q.size();
	end

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives directed and random rectangles and row words into the copy planner
// under several register settings, with random gaps and output stalls; the
// checker predicts and compares every result word
// ----------------------------------------------------------------------------
module testbench;
	import wbrc_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]      cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [0:0]            s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;
	logic                  m_axis_tlast;

	int mismatches;
	int outstanding;
	bit calm;
	int rx_hold;
	int rx_draw;
	int scr_w;
	int scr_h;
	int words_sent;

	always #5 clk = ~clk;

	banked_window_rect_copy_planner_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	copy_plan_checker plan_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	// random output side stall, possibly none, after each accepted word
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_hold <= 0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			rx_draw = calm ? 0 : $urandom_range(0, 17);
			rx_hold <= rx_draw;
			m_axis_tready <= (rx_draw == 0);
		end else if (rx_hold > 1) begin
			rx_hold <= rx_hold - 1;
		end else begin
			rx_hold <= 0;
			m_axis_tready <= 1'b1;
		end
	end

	task automatic send_word(input logic kind, input int l, input int t, input int r,
		input int b);
		int gap;
		if ($urandom_range(0, 15) == 0)
			calm = !calm;
		gap = calm ? 0 : $urandom_range(0, 17);
		repeat (gap) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {16'(b), 16'(r), 16'(t), 16'(l)};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		words_sent++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
	endtask

	task automatic configure(input int w, input int h, input int st, input int ap);
		drain();
		write_reg(REG_SCREEN_WIDTH, CFG_W'(w));
		write_reg(REG_SCREEN_HEIGHT, CFG_W'(h));
		write_reg(REG_ROW_STRIDE, CFG_W'(st));
		write_reg(REG_APERTURE_SIZE, CFG_W'(ap));
		cfg_we <= 1'b0;
		scr_w = (w & 32'h7fff) > 16384 ? 16384 : (w & 32'h7fff);
		scr_h = (h & 32'h7fff) > 16384 ? 16384 : (h & 32'h7fff);
	endtask

	// start word then its rows, sometimes cut short or overrun
	task automatic send_rect();
		int gw, gh, l, t, r, b, rows, n_rows;
		gw = (scr_w < 1) ? 1 : scr_w;
		gh = (scr_h < 1) ? 1 : scr_h;
		l = $urandom_range(0, gw - 1);
		if ($urandom_range(0, 7) == 0)
			l -= $urandom_range(1, 8);
		r = l + 1 + $urandom_range(0, gw / 2);
		if ($urandom_range(0, 7) == 0)
			r += $urandom_range(1, 8);
		t = $urandom_range(0, gh - 1);
		if ($urandom_range(0, 7) == 0)
			t -= $urandom_range(1, 4);
		b = t + 1 + $urandom_range(0, 5);
		rows = ((b > scr_h) ? scr_h : b) - ((t < 0) ? 0 : t);
		if (((r > scr_w) ? scr_w : r) - ((l < 0) ? 0 : l) < 1 || rows < 1)
			rows = 0;
		send_word(1'b0, l, t, r, b);
		n_rows = ($urandom_range(0, 7) == 0) ? $urandom_range(0, rows)
			: rows + $urandom_range(0, 1);
		repeat (n_rows)
			send_word(1'b1, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic run_random(input int n);
		int target;
		target = words_sent + n;
		while (words_sent < target) begin
			if ($urandom_range(0, 4) == 0)
				send_word(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
					$urandom);
			else
				send_rect();
		end
	endtask

	initial begin
		#3000000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		scr_w = 640;
		scr_h = 480;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default registers: 640x480, stride 640, 64k window
		send_word(1'b0, -32768, -32768, 32767, 32767);
		send_word(1'b1, 0, 0, 0, 0);
		send_word(1'b0, 100, 50, 100, 60);
		send_word(1'b1, -1, -1, -1, -1);
		send_word(1'b0, 5, 5, 3, 9);
		send_word(1'b0, 32767, 32767, -32768, -32768);
		send_word(1'b0, -32768, 0, -1, 5);
		// copy then bank select, then plain copy, then nothing left
		send_word(1'b0, 600, 101, 640, 103);
		send_word(1'b1, 0, 0, 0, 0);
		send_word(1'b1, 0, 0, 0, 0);
		send_word(1'b1, 0, 0, 0, 0);
		// split copy around a bank select
		send_word(1'b0, 0, 102, 640, 104);
		send_word(1'b1, 0, 0, 0, 0);
		send_word(1'b1, 0, 0, 0, 0);
		// room equal to the row length
		send_word(1'b0, 0, 102, 256, 103);
		send_word(1'b1, 0, 0, 0, 0);
		// start while a rectangle is still open
		send_word(1'b0, 0, 204, 10, 206);
		send_word(1'b1, 0, 0, 0, 0);
		send_word(1'b0, 620, 470, 700, 500);
		send_word(1'b1, 0, 0, 0, 0);
		send_word(1'b1, 0, 0, 0, 0);
		run_random(12);

		configure(32767, 16384, 131071, 27'h7ffffff);
		run_random(12);
		configure(1, 1, 1, 0);
		run_random(10);
		// stride beyond the window
		configure(64, 40, 300, 100);
		send_word(1'b0, 0, 0, 50, 3);
		send_word(1'b1, 0, 0, 0, 0);
		send_word(1'b1, 0, 0, 0, 0);
		send_word(1'b1, 0, 0, 0, 0);
		run_random(12);
		configure(0, 5, 7, 3);
		run_random(8);
		configure($urandom_range(1, 300), $urandom_range(1, 60), $urandom_range(1, 600),
			$urandom_range(1, 2000));
		run_random(15);
		configure(16384, 16384, 65536, 67108864);
		run_random(10);

		drain();
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/wbrc_pkg.sv
rtl/core/wbrc_div.sv
rtl/core/wbrc_dp.sv
rtl/core/wbrc_ctrl.sv
rtl/core/banked_window_rect_copy_planner_top.sv
verif/copy_plan_checker.sv
verif/testbench.sv
